@@ rtl/detector_anchor_decode_defines.svh @@
// Assertion helpers for the anchor decoder.
`ifndef DETECTOR_ANCHOR_DECODE_DEFINES_SVH
`define DETECTOR_ANCHOR_DECODE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, disabled while in reset.
`define DAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

@@ rtl/dad_pkg.sv @@
package dad_pkg;

  localparam int unsigned CLASS_W = 10;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned PAD_W   = 10;

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_SCORE  = 1'b1;

  typedef enum logic [2:0] {
    CFG_CONF_THRESHOLD = 3'd0,
    CFG_INV_SCALE      = 3'd1,
    CFG_PAD_LEFT       = 3'd2,
    CFG_PAD_TOP        = 3'd3,
    CFG_FRAME_WIDTH    = 3'd4,
    CFG_FRAME_HEIGHT   = 3'd5,
    CFG_USE_OBJECTNESS = 3'd6
  } dad_cfg_idx_e;

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] box_w;
    logic signed [COORD_W-1:0] box_h;
    logic [SCORE_W-1:0]        objectness;
    logic [SCORE_W-1:0]        class_score;
    logic                      last_score;
  } dad_req_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic [SCORE_W-1:0] confidence;
    logic [PIX_W-1:0]   left;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   width;
    logic [PIX_W-1:0]   height;
  } dad_res_t;

  typedef struct packed {
    logic [SCORE_W-1:0] conf_threshold;
    logic [15:0]        inv_scale;
    logic [PAD_W-1:0]   pad_left;
    logic [PAD_W-1:0]   pad_top;
    logic [PIX_W-1:0]   frame_width;
    logic [PIX_W-1:0]   frame_height;
    logic               use_objectness;
  } dad_cfg_t;

  // Finished anchor handed from the arg-max stage to the box math
  typedef struct packed {
    logic [CLASS_W-1:0]        class_index;
    logic [SCORE_W-1:0]        best_score;
    logic [SCORE_W-1:0]        objectness;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] box_w;
    logic signed [COORD_W-1:0] box_h;
  } dad_anchor_t;

endpackage

@@ rtl/dad_argmax.sv @@
module dad_argmax #(
  parameter int unsigned MAX_CLASSES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                req_valid_i,
  input  dad_pkg::dad_req_t   req_i,
  output logic                anchor_valid_o,
  output dad_pkg::dad_anchor_t anchor_o
);
  import dad_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CLASSES);
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_CLASSES - 1);

  logic signed [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d, w_q, w_d, h_q, h_d;
  logic [SCORE_W-1:0] obj_q, obj_d, bs_q, bs_d;
  logic [CW-1:0]      bc_q, bc_d, cnt_q, cnt_d;
  logic               full_q, full_d;
  logic               fire;
  logic               anchor_valid_q;
  dad_anchor_t        anchor_q, anchor_d;

  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    w_d    = w_q;
    h_d    = h_q;
    obj_d  = obj_q;
    bs_d   = bs_q;
    bc_d   = bc_q;
    cnt_d  = cnt_q;
    full_d = full_q;
    fire   = 1'b0;
    if (req_valid_i && (req_i.req_type == REQ_HEADER)) begin
      cx_d   = req_i.center_x;
      cy_d   = req_i.center_y;
      w_d    = req_i.box_w;
      h_d    = req_i.box_h;
      obj_d  = req_i.objectness;
      cnt_d  = '0;
      full_d = 1'b0;
    end else if (req_valid_i) begin
      if (!full_q) begin
        if ((cnt_q == '0) || (req_i.class_score > bs_q)) begin
          bs_d = req_i.class_score;
          bc_d = cnt_q;
        end
        if (cnt_q == CNT_LAST) begin
          full_d = 1'b1;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      if (req_i.last_score) begin
        cnt_d  = '0;
        full_d = 1'b0;
        fire   = 1'b1;
      end
    end
  end

  always_comb begin
    anchor_d.class_index = CLASS_W'(bc_d);
    anchor_d.best_score  = bs_d;
    anchor_d.objectness  = obj_q;
    anchor_d.center_x    = cx_q;
    anchor_d.center_y    = cy_q;
    anchor_d.box_w       = w_q;
    anchor_d.box_h       = h_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q           <= '0;
      cy_q           <= '0;
      w_q            <= '0;
      h_q            <= '0;
      obj_q          <= '0;
      bs_q           <= '0;
      bc_q           <= '0;
      cnt_q          <= '0;
      full_q         <= 1'b0;
      anchor_valid_q <= 1'b0;
    end else begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      w_q    <= w_d;
      h_q    <= h_d;
      obj_q  <= obj_d;
      bs_q   <= bs_d;
      bc_q   <= bc_d;
      cnt_q  <= cnt_d;
      full_q <= full_d;
      if (adv_i) begin
        anchor_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && fire) begin
      anchor_q <= anchor_d;
    end
  end

  assign anchor_valid_o = anchor_valid_q;
  assign anchor_o       = anchor_q;

endmodule

@@ rtl/dad_box_map.sv @@
module dad_box_map (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  dad_pkg::dad_cfg_t    cfg_i,
  input  logic                 anchor_valid_i,
  input  dad_pkg::dad_anchor_t anchor_i,
  output logic                 res_valid_o,
  output dad_pkg::dad_res_t    res_o
);
  import dad_pkg::*;

  // (twice_pos - pad*32) * inv_scale, Q.17
  function automatic logic signed [35:0] edge_prod(
    input logic signed [17:0] twice_pos,
    input logic [PAD_W-1:0]   pad,
    input logic [15:0]        scale
  );
    logic signed [18:0] diff;
    logic signed [16:0] sc;
    diff = 19'(twice_pos) - $signed({4'b0, pad, 5'b0});
    sc   = $signed({1'b0, scale});
    return 36'(diff * sc);
  endfunction

  // clamp to [0, limit << 17], round half up
  function automatic logic [PIX_W-1:0] edge_round(
    input logic signed [35:0] v,
    input logic [PIX_W-1:0]   limit
  );
    logic [28:0] hi;
    logic [28:0] cl;
    logic [29:0] sum;
    hi = {limit, 17'b0};
    if (v < 0) begin
      cl = '0;
    end else if (v > $signed({7'b0, hi})) begin
      cl = hi;
    end else begin
      cl = v[28:0];
    end
    sum = {1'b0, cl} + 30'd65536;
    return sum[28:17];
  endfunction

  logic signed [17:0] tl, tr, tt, tb;
  logic signed [35:0] pl_q, pr_q, pt_q, pb_q;
  logic [31:0]        cprod_q;
  logic [SCORE_W-1:0] best_q;
  logic [CLASS_W-1:0] cls_q;
  logic               p2_valid_q;

  logic [32:0]        cround;
  logic [SCORE_W-1:0] conf;
  logic [PIX_W-1:0]   l, r, t, b;

  always_comb begin
    tl = {anchor_i.center_x[15], anchor_i.center_x, 1'b0} - 18'(anchor_i.box_w);
    tr = {anchor_i.center_x[15], anchor_i.center_x, 1'b0} + 18'(anchor_i.box_w);
    tt = {anchor_i.center_y[15], anchor_i.center_y, 1'b0} - 18'(anchor_i.box_h);
    tb = {anchor_i.center_y[15], anchor_i.center_y, 1'b0} + 18'(anchor_i.box_h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (adv_i) begin
      p2_valid_q <= anchor_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && anchor_valid_i) begin
      pl_q    <= edge_prod(tl, cfg_i.pad_left, cfg_i.inv_scale);
      pr_q    <= edge_prod(tr, cfg_i.pad_left, cfg_i.inv_scale);
      pt_q    <= edge_prod(tt, cfg_i.pad_top, cfg_i.inv_scale);
      pb_q    <= edge_prod(tb, cfg_i.pad_top, cfg_i.inv_scale);
      cprod_q <= anchor_i.objectness * anchor_i.best_score;
      best_q  <= anchor_i.best_score;
      cls_q   <= anchor_i.class_index;
    end
  end

  always_comb begin
    cround = {1'b0, cprod_q} + 33'd32768;
    conf   = cfg_i.use_objectness ? cround[31:16] : best_q;
    l      = edge_round(pl_q, cfg_i.frame_width);
    r      = edge_round(pr_q, cfg_i.frame_width);
    t      = edge_round(pt_q, cfg_i.frame_height);
    b      = edge_round(pb_q, cfg_i.frame_height);
    res_o.class_index = cls_q;
    res_o.confidence  = conf;
    res_o.left        = l;
    res_o.top         = t;
    res_o.width       = (r > l) ? (r - l) : '0;
    res_o.height      = (b > t) ? (b - t) : '0;
    res_valid_o       = p2_valid_q && (conf > cfg_i.conf_threshold);
  end

endmodule

@@ rtl/detector_anchor_decode.sv @@
// A finished box passes the arg-max anchor, box-map product and output registers in turn.
// Throughput: one request per cycle while in_stall_o is low; header and score requests alike.
// The output register is backed by one skid entry; input stalls only while that entry is full.
// Reset (async, active low) clears the arg-max state, box and pipeline valids, and loads
// the configuration defaults; no clearing pass is needed.
`include "detector_anchor_decode_defines.svh"

module detector_anchor_decode #(
  parameter int unsigned MAX_CLASSES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dad_pkg::dad_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dad_pkg::dad_res_t out_res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import dad_pkg::*;

  dad_cfg_t    cfg_q;
  logic        adv;
  logic        in_acc;
  logic        anchor_valid;
  dad_anchor_t anchor;
  logic        res_valid;
  dad_res_t    res;

  logic     out_valid_q, skid_valid_q;
  dad_res_t out_q, skid_q;
  logic     out_take, out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_threshold <= 16'd16384;
      cfg_q.inv_scale      <= 16'd4096;
      cfg_q.pad_left       <= '0;
      cfg_q.pad_top        <= '0;
      cfg_q.frame_width    <= 12'd640;
      cfg_q.frame_height   <= 12'd640;
      cfg_q.use_objectness <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (dad_cfg_idx_e'(cfg_index_i))
        CFG_CONF_THRESHOLD: cfg_q.conf_threshold <= cfg_data_i;
        CFG_INV_SCALE:      cfg_q.inv_scale      <= cfg_data_i;
        CFG_PAD_LEFT:       cfg_q.pad_left       <= cfg_data_i[PAD_W-1:0];
        CFG_PAD_TOP:        cfg_q.pad_top        <= cfg_data_i[PAD_W-1:0];
        CFG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i[PIX_W-1:0];
        CFG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i[PIX_W-1:0];
        CFG_USE_OBJECTNESS: cfg_q.use_objectness <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  dad_argmax #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_argmax (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .req_valid_i    (in_acc),
    .req_i          (in_req_i),
    .anchor_valid_o (anchor_valid),
    .anchor_o       (anchor)
  );

  dad_box_map u_box_map (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .cfg_i          (cfg_q),
    .anchor_valid_i (anchor_valid),
    .anchor_i       (anchor),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `DAD_ASSERT_IMP(a_skid_backs_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `DAD_ASSERT_IMP(a_skid_fill_on_stall, clk_i, rst_ni, $rose(skid_valid_q), $past(out_valid_q && out_stall_i))
  `DAD_ASSERT_NXT(a_skid_drains, clk_i, rst_ni, skid_valid_q && !out_stall_i, !skid_valid_q && out_valid_q)

endmodule

@@ sim/tb_detector_anchor_decode.sv @@
`timescale 1ns / 1ps

module tb_detector_anchor_decode;
  import dad_pkg::*;

  localparam int unsigned ANCHOR_CLASSES = 1024;
  localparam int unsigned RANDOM_ITEMS   = 800;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned SETTLE         = 12;
  localparam int unsigned QUIET_LIMIT    = 2000;

  logic        clk;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  dad_req_t    in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  dad_res_t    out_res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  detector_anchor_decode #(
    .MAX_CLASSES(ANCHOR_CLASSES)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow of the block: settings, held box, running arg-max
  dad_cfg_t    shadow;
  longint      box_cx, box_cy, box_w, box_h;
  logic [15:0] held_obj;
  logic [15:0] top_score;
  logic [9:0]  top_class;
  int unsigned score_idx;
  bit          idx_full;

  dad_res_t    pending_boxes[$];
  int unsigned errors = 0;
  int unsigned items_sent;
  int unsigned quiet_cycles = 0;
  bit          idle_en;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  function automatic logic [11:0] frame_pixel(longint twice, longint pad, longint limit);
    longint v;
    v = (twice - pad * 32) * longint'(shadow.inv_scale);
    if (v < 0) v = 0;
    if (v > (limit <<< 17)) v = limit <<< 17;
    return 12'((v + 65536) >>> 17);
  endfunction

  function automatic void decode_request(dad_req_t r);
    int unsigned conf;
    logic [11:0] l, t, rt, bt;
    dad_res_t    res;
    if (r.req_type == REQ_HEADER) begin
      box_cx    = $signed(r.center_x);
      box_cy    = $signed(r.center_y);
      box_w     = $signed(r.box_w);
      box_h     = $signed(r.box_h);
      held_obj  = r.objectness;
      score_idx = 0;
      idx_full  = 1'b0;
      return;
    end
    if (!idx_full) begin
      if (score_idx == 0 || r.class_score > top_score) begin
        top_score = r.class_score;
        top_class = 10'(score_idx);
      end
      if (score_idx >= ANCHOR_CLASSES - 1) idx_full = 1'b1;
      else score_idx++;
    end
    if (!r.last_score) return;
    score_idx = 0;
    idx_full  = 1'b0;
    if (shadow.use_objectness) begin
      conf = (32'(held_obj) * 32'(top_score) + 32'd32768) >> 16;
    end else begin
      conf = top_score;
    end
    if (conf <= shadow.conf_threshold) return;
    l  = frame_pixel(2 * box_cx - box_w, shadow.pad_left, shadow.frame_width);
    rt = frame_pixel(2 * box_cx + box_w, shadow.pad_left, shadow.frame_width);
    t  = frame_pixel(2 * box_cy - box_h, shadow.pad_top, shadow.frame_height);
    bt = frame_pixel(2 * box_cy + box_h, shadow.pad_top, shadow.frame_height);
    res.class_index = top_class;
    res.confidence  = 16'(conf);
    res.left        = l;
    res.top         = t;
    res.width       = (rt > l) ? rt - l : '0;
    res.height      = (bt > t) ? bt - t : '0;
    pending_boxes = {pending_boxes, res};
  endfunction

  function automatic dad_req_t noise_req();
    dad_req_t r;
    r.req_type    = 1'($urandom);
    r.center_x    = 16'($urandom);
    r.center_y    = 16'($urandom);
    r.box_w       = 16'($urandom);
    r.box_h       = 16'($urandom);
    r.objectness  = 16'($urandom);
    r.class_score = 16'($urandom);
    r.last_score  = 1'($urandom);
    return r;
  endfunction

  function automatic dad_req_t header_item(logic [15:0] cx, logic [15:0] cy, logic [15:0] w,
                                           logic [15:0] h, logic [15:0] obj, logic last);
    dad_req_t r;
    r            = noise_req();
    r.req_type   = REQ_HEADER;
    r.center_x   = cx;
    r.center_y   = cy;
    r.box_w      = w;
    r.box_h      = h;
    r.objectness = obj;
    r.last_score = last;
    return r;
  endfunction

  function automatic dad_req_t score_item(logic [15:0] score, logic last);
    dad_req_t r;
    r             = noise_req();
    r.req_type    = REQ_SCORE;
    r.class_score = score;
    r.last_score  = last;
    return r;
  endfunction

  // called right after a rising edge; returns at the edge that accepts the request
  task automatic push_request(input dad_req_t r);
    bit ok;
    while (idle_en && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do begin
      @(negedge clk);
      ok = !in_stall_o;
      @(posedge clk);
    end while (!ok);
    decode_request(r);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input dad_cfg_idx_e idx, input logic [15:0] data);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk);
      ok = cfg_ready_o;
      @(posedge clk);
    end while (!ok);
    case (idx)
      CFG_CONF_THRESHOLD: shadow.conf_threshold = data;
      CFG_INV_SCALE:      shadow.inv_scale      = data;
      CFG_PAD_LEFT:       shadow.pad_left       = data[9:0];
      CFG_PAD_TOP:        shadow.pad_top        = data[9:0];
      CFG_FRAME_WIDTH:    shadow.frame_width    = data[11:0];
      CFG_FRAME_HEIGHT:   shadow.frame_height   = data[11:0];
      CFG_USE_OBJECTNESS: shadow.use_objectness = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input dad_cfg_t c);
    drain();
    cfg_write(CFG_CONF_THRESHOLD, c.conf_threshold);
    cfg_write(CFG_INV_SCALE, c.inv_scale);
    cfg_write(CFG_PAD_LEFT, 16'(c.pad_left));
    cfg_write(CFG_PAD_TOP, 16'(c.pad_top));
    cfg_write(CFG_FRAME_WIDTH, 16'(c.frame_width));
    cfg_write(CFG_FRAME_HEIGHT, 16'(c.frame_height));
    cfg_write(CFG_USE_OBJECTNESS, 16'(c.use_objectness));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic dad_cfg_t rand_settings();
    dad_cfg_t c;
    case ($urandom_range(5))
      0:       c.conf_threshold = 16'd0;
      1:       c.conf_threshold = 16'hFFFF;
      2:       c.conf_threshold = 16'($urandom);
      default: c.conf_threshold = 16'($urandom_range(20000));
    endcase
    case ($urandom_range(5))
      0:       c.inv_scale = 16'd1;
      1:       c.inv_scale = 16'hFFFF;
      2:       c.inv_scale = 16'($urandom_range(1, 65535));
      default: c.inv_scale = 16'($urandom_range(2048, 12288));
    endcase
    c.pad_left       = ($urandom_range(3) == 0) ? 10'd640 : 10'($urandom_range(640));
    c.pad_top        = ($urandom_range(3) == 0) ? 10'd0 : 10'($urandom_range(640));
    c.frame_width    = ($urandom_range(4) == 0) ? 12'd4095 : 12'($urandom_range(1, 4095));
    c.frame_height   = ($urandom_range(4) == 0) ? 12'd1 : 12'($urandom_range(1, 4095));
    c.use_objectness = 1'($urandom);
    return c;
  endfunction

  function automatic logic [15:0] rand_coord();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12000));
  endfunction

  function automatic logic [15:0] rand_size();
    return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
  endfunction

  function automatic logic [15:0] rand_score();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(3) * 21845);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_anchor();
    int unsigned kind, n;
    kind = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
    if (kind < 88) begin
      push_request(header_item(rand_coord(), rand_coord(), rand_size(), rand_size(),
                               16'($urandom), 1'($urandom)));
      for (int unsigned i = 0; i < n; i++) push_request(score_item(rand_score(), i == n - 1));
    end else if (kind < 94) begin
      for (int unsigned i = 0; i < n % 6 + 1; i++)
        push_request(score_item(rand_score(), i == n % 6));
    end else begin
      push_request(noise_req());
      for (int unsigned i = 0; i < n % 4; i++) push_request(score_item(rand_score(), 1'b0));
    end
  endtask

  task automatic test_reset_defaults();
    push_request(score_item(16'hFFFF, 1'b1));
    push_request(header_item(16'd5120, 16'd3840, 16'd1600, 16'd800, 16'hFFFF, 1'b1));
    push_request(score_item(16'd100, 1'b0));
    push_request(score_item(16'd40000, 1'b0));
    push_request(score_item(16'd40000, 1'b0));
    push_request(score_item(16'd39999, 1'b1));
    push_request(score_item(16'd16384, 1'b1));
    push_request(score_item(16'd16385, 1'b1));
  endtask

  task automatic test_argmax_order();
    push_request(header_item(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 1'b0));
    push_request(score_item(16'd0, 1'b0));
    push_request(score_item(16'hFFFF, 1'b1));
    push_request(header_item(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0));
    push_request(score_item(16'hFFFF, 1'b1));
  endtask

  task automatic test_setting_extremes();
    apply_settings('{16'd0, 16'hFFFF, 10'd640, 10'd640, 12'd4095, 12'd4095, 1'b1});
    push_request(header_item(16'd11200, 16'd10400, 16'd800, 16'd640, 16'hFFFF, 1'b0));
    push_request(score_item(16'hFFFF, 1'b1));
    push_request(header_item(16'd11200, 16'd10400, 16'd800, 16'd640, 16'd1, 1'b0));
    push_request(score_item(16'd1, 1'b1));
    push_request(header_item(16'd10300, 16'd10300, 16'd320, 16'd320, 16'h8000, 1'b0));
    push_request(score_item(16'd1, 1'b1));
    apply_settings('{16'hFFFF, 16'd1, 10'd0, 10'd0, 12'd1, 12'd1, 1'b0});
    push_request(header_item(16'd4000, 16'd4000, 16'd400, 16'd400, 16'd0, 1'b0));
    push_request(score_item(16'hFFFF, 1'b1));
    apply_settings('{16'd0, 16'd0, 10'd0, 10'd0, 12'd0, 12'd0, 1'b0});
    push_request(header_item(16'd4000, 16'd2000, 16'd400, 16'd400, 16'd0, 1'b0));
    push_request(score_item(16'd1, 1'b1));
    apply_settings('{16'd0, 16'd4096, 10'd0, 10'd0, 12'd1, 12'd1, 1'b0});
    push_request(header_item(16'd8, 16'd8, 16'd16, 16'd16, 16'd0, 1'b0));
    push_request(score_item(16'd1, 1'b1));
  endtask

  task automatic test_class_overflow();
    apply_settings('{16'd0, 16'd4096, 10'd0, 10'd0, 12'd640, 12'd480, 1'b0});
    push_request(header_item(16'd3200, 16'd2400, 16'd960, 16'd640, 16'd0, 1'b0));
    for (int unsigned i = 0; i < ANCHOR_CLASSES + 6; i++) begin
      if (i == ANCHOR_CLASSES - 1)      push_request(score_item(16'd60000, 1'b0));
      else if (i == ANCHOR_CLASSES + 3) push_request(score_item(16'hFFFF, 1'b0));
      else push_request(score_item(16'($urandom_range(50000)), i == ANCHOR_CLASSES + 5));
    end
    push_request(score_item(16'd10, 1'b0));
    push_request(score_item(16'd20, 1'b1));
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    for (int unsigned p = 0; p < PHASES; p++) begin
      apply_settings(rand_settings());
      idle_en = (p != 3);
      goal = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < goal) begin
        random_anchor();
        if ($urandom_range(199) == 0) drain();
      end
    end
    idle_en = 1'b1;
  endtask

  always @(posedge clk) out_stall_i <= idle_en && ($urandom_range(99) < 29);

  always @(negedge clk) begin : check_boxes
    dad_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_boxes.size() == 0) begin
        report($sformatf("unexpected box class %0d", out_res_o.class_index));
      end else begin
        want = pending_boxes.pop_front();
        if (out_res_o.class_index !== want.class_index)
          report($sformatf("class_index got %0d want %0d",
                           out_res_o.class_index, want.class_index));
        if (out_res_o.confidence !== want.confidence)
          report($sformatf("confidence got %0d want %0d",
                           out_res_o.confidence, want.confidence));
        if (out_res_o.left !== want.left)
          report($sformatf("left got %0d want %0d", out_res_o.left, want.left));
        if (out_res_o.top !== want.top)
          report($sformatf("top got %0d want %0d", out_res_o.top, want.top));
        if (out_res_o.width !== want.width)
          report($sformatf("width got %0d want %0d", out_res_o.width, want.width));
        if (out_res_o.height !== want.height)
          report($sformatf("height got %0d want %0d", out_res_o.height, want.height));
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk          = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_CONF_THRESHOLD;
    cfg_data_i  <= '0;
    shadow       = '{16'd16384, 16'd4096, 10'd0, 10'd0, 12'd640, 12'd640, 1'b0};
    box_cx       = 0;
    box_cy       = 0;
    box_w        = 0;
    box_h        = 0;
    held_obj     = '0;
    top_score    = '0;
    top_class    = '0;
    score_idx    = 0;
    idx_full     = 1'b0;
    items_sent   = 0;
    idle_en      = 1'b1;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_argmax_order();
    test_setting_extremes();
    test_class_overflow();
    test_random_traffic();
    drain();
    if (errors == 0 && pending_boxes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dad_pkg.sv
rtl/dad_argmax.sv
rtl/dad_box_map.sv
rtl/detector_anchor_decode.sv
sim/tb_detector_anchor_decode.sv
